### design/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/uer_pkg.sv
`default_nettype none

package uer_pkg;

  // Field widths.
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned TICKS_W  = 20;
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned DIST_W   = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Distance is width * 8 / 29, done as a multiply by a rounded-up
  // reciprocal of 29 (scaled by 2^25) and a shift; exact for all 16-bit widths.
  localparam int unsigned RECIP_W    = 21;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 21'd1157050;
  localparam int unsigned DIST_SHIFT = 22;
  localparam int unsigned PROD_W     = WIDTH_W + RECIP_W;

  // Measurement phases.
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LOW  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RISE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MEAS = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TO  = 2'd3;

  // Reset values of the registers.
  localparam logic [TRIG_W-1:0]  TRIG_LOW_RST  = 8'd2;
  localparam logic [TRIG_W-1:0]  TRIG_HIGH_RST = 8'd10;
  localparam logic [TICKS_W-1:0] TIMEOUT_RST   = 20'd1000000;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic                trigger_level;
    logic                busy_res;
    logic                done_res;
    logic                status;
    logic [WIDTH_W-1:0]  echo_width_us;
    logic [DIST_W-1:0]   distance_cm_q4;
  } out_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_low_us;
    logic [TRIG_W-1:0]  trigger_high_us;
    logic [TICKS_W-1:0] rise_timeout_us;
    logic [TICKS_W-1:0] width_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TICKS_W-1:0] phase_ticks;
    logic [WIDTH_W-1:0] pulse_width;
    logic [WIDTH_W-1:0] last_width;
    logic               last_status;
    logic [DIST_W-1:0]  last_dist;
  } state_t;

endpackage

`default_nettype wire

### design/uer_step.sv
`default_nettype none

module uer_step (
  input  uer_pkg::cfg_t   cfg_i,
  input  uer_pkg::state_t state_i,
  input  uer_pkg::in_t    word_i,
  output uer_pkg::state_t state_o,
  output uer_pkg::out_t   word_o
);
  import uer_pkg::*;

  logic [TICKS_W-1:0] ticks_inc;
  logic               finish;
  logic [WIDTH_W-1:0] fin_width;
  logic               trig;
  logic [PROD_W-1:0]  prod;

  assign ticks_inc = state_i.phase_ticks + TICKS_W'(1);

  // One tick of the measurement sequencer.
  always_comb begin
    state_o   = state_i;
    finish    = 1'b0;
    fin_width = '0;
    trig      = 1'b0;
    case (state_i.phase)
      PH_LOW: begin
        state_o.phase_ticks = ticks_inc;
        if (ticks_inc >= TICKS_W'(cfg_i.trigger_low_us)) begin
          state_o.phase       = PH_HIGH;
          state_o.phase_ticks = '0;
        end
      end
      PH_HIGH: begin
        trig                = 1'b1;
        state_o.phase_ticks = ticks_inc;
        if (ticks_inc >= TICKS_W'(cfg_i.trigger_high_us)) begin
          state_o.phase       = PH_RISE;
          state_o.phase_ticks = '0;
        end
      end
      PH_RISE: begin
        if (word_i.echo_level) begin
          // The first high tick already counts as one microsecond.
          state_o.pulse_width = WIDTH_W'(1);
          state_o.phase_ticks = TICKS_W'(1);
          state_o.phase       = PH_MEAS;
          if (TICKS_W'(1) >= cfg_i.width_timeout_us) begin
            finish    = 1'b1;
            fin_width = WIDTH_W'(1);
          end
        end else begin
          state_o.phase_ticks = ticks_inc;
          if (ticks_inc >= cfg_i.rise_timeout_us) begin
            finish    = 1'b1;
            fin_width = '0;
          end
        end
      end
      PH_MEAS: begin
        if (word_i.echo_level) begin
          state_o.phase_ticks = ticks_inc;
          if (state_i.pulse_width != '1) begin
            state_o.pulse_width = state_i.pulse_width + WIDTH_W'(1);
          end
          if (ticks_inc >= cfg_i.width_timeout_us) begin
            finish    = 1'b1;
            fin_width = state_o.pulse_width;
          end
        end else begin
          finish    = 1'b1;
          fin_width = state_i.pulse_width;
        end
      end
      default: begin
        state_o.phase = PH_IDLE;
        if (word_i.start_req) begin
          state_o.phase       = (cfg_i.trigger_low_us != '0) ? PH_LOW : PH_HIGH;
          state_o.phase_ticks = '0;
          state_o.pulse_width = '0;
        end
      end
    endcase

    // Distance in Q4 centimeters from the completed width.
    prod = PROD_W'(fin_width) * PROD_W'(DIST_RECIP);

    // Completion latches the width, its status and the distance.
    if (finish) begin
      state_o.last_width  = fin_width;
      state_o.last_status = (fin_width == '0);
      state_o.last_dist   = prod[DIST_SHIFT +: DIST_W];
      state_o.phase       = PH_IDLE;
      state_o.phase_ticks = '0;
    end
  end

  // Result word for this tick.
  always_comb begin
    word_o.trigger_level  = trig;
    word_o.busy_res       = (state_o.phase != PH_IDLE);
    word_o.done_res       = finish;
    word_o.status         = state_o.last_status;
    word_o.echo_width_us  = state_o.last_width;
    word_o.distance_cm_q4 = state_o.last_dist;
  end

endmodule

`default_nettype wire

### design/ultrasonic_echo_ranger_unit.sv
// Channel   Direction  Handshake                Word
// input     in         in_valid_i / in_stall_o  in_word_i   (start_req, echo_level)
// output    out        out_valid_o / out_stall_i out_word_o (trigger, busy, done, result)
// config    in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// Each accepted word (one microsecond tick) yields exactly one result word,
// computed combinationally into the output register, so a word per cycle is sustained
// while out_stall_i is low. The output register is the only stage: while it holds a
// word and out_stall_i is high, in_stall_o is high. Reset clears the phase,
// the counters, the last result and loads the register defaults.
`default_nettype none

module ultrasonic_echo_ranger_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  uer_pkg::in_t                       in_word_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output uer_pkg::out_t                      out_word_o,
  input  wire                                cfg_we_i,
  input  wire  [uer_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [uer_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import uer_pkg::*;

  `include "assert_macros.svh"

  cfg_t   cfg_q;
  state_t state_q, state_d;
  out_t   out_q, out_d;
  logic   out_valid_q;
  logic   in_accept;

  // The output register can take a word when empty or being drained.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  uer_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .word_i  (in_word_i),
    .state_o (state_d),
    .word_o  (out_d)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_low_us   <= TRIG_LOW_RST;
      cfg_q.trigger_high_us  <= TRIG_HIGH_RST;
      cfg_q.rise_timeout_us  <= TIMEOUT_RST;
      cfg_q.width_timeout_us <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TRIG_LOW:  cfg_q.trigger_low_us   <= cfg_data_i[TRIG_W-1:0];
        REG_TRIG_HIGH: cfg_q.trigger_high_us  <= cfg_data_i[TRIG_W-1:0];
        REG_RISE_TO:   cfg_q.rise_timeout_us  <= cfg_data_i[TICKS_W-1:0];
        REG_WIDTH_TO:  cfg_q.width_timeout_us <= cfg_data_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  `ASSERT_IMPLY(a_done_not_busy, out_valid_q && out_q.done_res, !out_q.busy_res,
    "Completed measurement still reported busy.")
  `ASSERT_IMPLY(a_trig_busy, out_valid_q && out_q.trigger_level, out_q.busy_res,
    "Trigger driven outside a measurement.")
  `ASSERT_IMPLY(a_no_echo_zero, state_q.last_status, state_q.last_width == '0,
    "No-echo status with a nonzero width.")
  `ASSERT_IMPLY(a_meas_width, state_q.phase == PH_MEAS, state_q.pulse_width != '0,
    "Echo measurement running with zero width.")
  `ASSERT_IMPLY(a_idle_hold, !in_accept, ##1 $stable(state_q),
    "Sequencer state moved without an accepted word.")

endmodule

`default_nettype wire

### sim/ultrasonic_echo_ranger_unit_tb.sv
module ultrasonic_echo_ranger_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Stimulus side of the block.
  logic                  tick_valid = 1'b0;
  in_t                   tick_word = '0;
  logic                  tick_stall;
  logic                  report_valid;
  logic                  report_stall = 1'b0;
  out_t                  report_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_echo_ranger_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_word_i   (tick_word),
    .out_valid_o (report_valid),
    .out_stall_i (report_stall),
    .out_word_o  (report_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Words waiting to be offered, and reports predicted but not yet seen.
  in_t         tick_backlog[$];
  out_t        pending_reports[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;

  // Shadow of the ranger: registers and measurement state.
  cfg_t               rg_cfg = '{TRIG_LOW_RST, TRIG_HIGH_RST, TIMEOUT_RST, TIMEOUT_RST};
  logic [PHASE_W-1:0] rg_phase = PH_IDLE;
  logic [TICKS_W-1:0] rg_ticks = '0;
  logic [WIDTH_W-1:0] rg_width = '0;
  logic [WIDTH_W-1:0] rg_last_width = '0;
  logic               rg_no_echo = 1'b0;

  // Sender and receiver pacing.
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_left = 0;
  logic        rx_hold = 1'b0;
  logic        squeeze_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A measurement ends: latch the width and return to idle.
  function automatic void close_measurement(input logic [WIDTH_W-1:0] width);
    rg_last_width = width;
    rg_no_echo    = (width == '0);
    rg_phase      = PH_IDLE;
    rg_ticks      = '0;
  endfunction

  // Advances the shadow by one microsecond tick and returns the report word.
  function automatic out_t ranger_tick(input in_t w);
    out_t r;
    logic trig;
    logic done;
    trig = 1'b0;
    done = 1'b0;
    case (rg_phase)
      PH_LOW: begin
        rg_ticks = rg_ticks + 1'b1;
        if (rg_ticks >= rg_cfg.trigger_low_us) begin
          rg_phase = PH_HIGH;
          rg_ticks = '0;
        end
      end
      PH_HIGH: begin
        trig = 1'b1;
        rg_ticks = rg_ticks + 1'b1;
        if (rg_ticks >= rg_cfg.trigger_high_us) begin
          rg_phase = PH_RISE;
          rg_ticks = '0;
        end
      end
      PH_RISE: begin
        if (w.echo_level) begin
          rg_width = 1;
          rg_ticks = 1;
          rg_phase = PH_MEAS;
          if (rg_ticks >= rg_cfg.width_timeout_us) begin
            close_measurement(rg_width);
            done = 1'b1;
          end
        end else begin
          rg_ticks = rg_ticks + 1'b1;
          if (rg_ticks >= rg_cfg.rise_timeout_us) begin
            close_measurement('0);
            done = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (w.echo_level) begin
          rg_ticks = rg_ticks + 1'b1;
          if (rg_width != '1) rg_width = rg_width + 1'b1;
          if (rg_ticks >= rg_cfg.width_timeout_us) begin
            close_measurement(rg_width);
            done = 1'b1;
          end
        end else begin
          close_measurement(rg_width);
          done = 1'b1;
        end
      end
      default: begin
        rg_phase = PH_IDLE;
        if (w.start_req) begin
          rg_phase = (rg_cfg.trigger_low_us != '0) ? PH_LOW : PH_HIGH;
          rg_ticks = '0;
          rg_width = '0;
        end
      end
    endcase
    r.trigger_level  = trig;
    r.busy_res       = (rg_phase != PH_IDLE);
    r.done_res       = done;
    r.status         = rg_no_echo;
    r.echo_width_us  = rg_last_width;
    r.distance_cm_q4 = DIST_W'((32'(rg_last_width) * 32'd16) / 32'd58);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers the next backlog word once the previous one is taken.
  always @(posedge clk_i) begin : tick_drive
    int unsigned r;
    if (rst_ni && (!tick_valid || !tick_stall)) begin
      if (tx_gap != 0) begin
        tx_gap--;
        tick_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        tick_word  <= tick_backlog.pop_front();
        tick_valid <= 1'b1;
        if (tx_calm != 0) begin
          tx_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) tx_calm = 100;
          else if (r < 57) tx_gap = 0;
          else if (r < 85) tx_gap = $urandom_range(1, 3);
          else if (r < 97) tx_gap = $urandom_range(4, 12);
          else tx_gap = $urandom_range(15, 30);
        end
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  always @(posedge clk_i) begin : report_pace
    int unsigned r;
    if (rst_ni) begin
      if (rx_left != 0) begin
        rx_left--;
      end else if (!squeeze_done && reports_seen >= 200) begin
        squeeze_done = 1'b1;
        rx_hold = 1'b1;
        rx_left = 300;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          rx_hold = 1'b0;
          rx_left = 100;
        end else if (r < 60) begin
          rx_hold = 1'b0;
          rx_left = $urandom_range(0, 8);
        end else if (r < 92) begin
          rx_hold = 1'b1;
          rx_left = $urandom_range(0, 2);
        end else begin
          rx_hold = 1'b1;
          rx_left = $urandom_range(8, 30);
        end
      end
      report_stall <= rx_hold;
    end
  end

  // Monitor: checks each report word and predicts for each accepted tick.
  always @(posedge clk_i) begin : report_check
    out_t want;
    if (rst_ni) begin
      if (report_valid && !report_stall) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report word, expected none, actual %h",
                   $time, report_word);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("trigger_level", want.trigger_level, report_word.trigger_level);
          check_field("busy_res", want.busy_res, report_word.busy_res);
          check_field("done_res", want.done_res, report_word.done_res);
          check_field("status", want.status, report_word.status);
          check_field("echo_width_us", want.echo_width_us, report_word.echo_width_us);
          check_field("distance_cm_q4", want.distance_cm_q4, report_word.distance_cm_q4);
        end
      end
      if (tick_valid && !tick_stall) begin
        pending_reports.push_back(ranger_tick(tick_word));
        accepted_count++;
      end
    end
  end

  task automatic push_tick(input logic start, input logic echo);
    tick_backlog.push_back('{start_req: start, echo_level: echo});
    queued_count++;
  endtask

  // Waits until every queued word was taken and every report has come back.
  task automatic drain_ticks();
    while (accepted_count != queued_count || pending_reports.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_ticks();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_TRIG_LOW:  rg_cfg.trigger_low_us   = val[TRIG_W-1:0];
      REG_TRIG_HIGH: rg_cfg.trigger_high_us  = val[TRIG_W-1:0];
      REG_RISE_TO:   rg_cfg.rise_timeout_us  = val[TICKS_W-1:0];
      REG_WIDTH_TO:  rg_cfg.width_timeout_us = val[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  // One measurement: start, trigger ticks, rise wait, echo high, echo low.
  task automatic queue_measurement(input int unsigned rise_wait,
                                   input int unsigned echo_len);
    int unsigned lead;
    lead = int'(rg_cfg.trigger_low_us) +
           ((rg_cfg.trigger_high_us == '0) ? 1 : int'(rg_cfg.trigger_high_us));
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (lead) push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    repeat (rise_wait) push_tick($urandom_range(0, 3) == 0, 1'b0);
    repeat (echo_len) push_tick($urandom_range(0, 3) == 0, 1'b1);
    push_tick(1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned r;
    int unsigned rise_cap;
    int unsigned echo_cap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero settings: no low phase, one-tick pulse and one-tick timeouts.
    write_reg(REG_TRIG_LOW, '0);
    write_reg(REG_TRIG_HIGH, '0);
    write_reg(REG_RISE_TO, '0);
    write_reg(REG_WIDTH_TO, '0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);

    // Width ends on the width timeout; start while busy is ignored.
    write_reg(REG_TRIG_LOW, 1);
    write_reg(REG_TRIG_HIGH, 1);
    write_reg(REG_RISE_TO, 3);
    write_reg(REG_WIDTH_TO, 4);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);

    // A register write in the middle of a measurement takes effect at once.
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    write_reg(REG_WIDTH_TO, 1);
    push_tick(1'b0, 1'b1);

    // Width ends on the falling echo.
    write_reg(REG_WIDTH_TO, 1000);
    queue_measurement(0, 2);

    // Longest trigger phases.
    write_reg(REG_TRIG_LOW, 255);
    write_reg(REG_TRIG_HIGH, 255);
    write_reg(REG_RISE_TO, 5);
    write_reg(REG_WIDTH_TO, 20);
    queue_measurement(2, 7);

    // Largest timeouts, with the echo ending on its falling edge.
    write_reg(REG_TRIG_LOW, 2);
    write_reg(REG_TRIG_HIGH, 3);
    write_reg(REG_RISE_TO, (1 << TICKS_W) - 1);
    write_reg(REG_WIDTH_TO, (1 << TICKS_W) - 1);
    queue_measurement(3, 40);

    // Random settings, each followed by a burst of measurements and noise.
    base = queued_count;
    while (queued_count - base < 300) begin
      if (queued_count == base || $urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        write_reg(REG_TRIG_LOW, (r < 2) ? 0 : (r < 8) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 12));
      end
      if (queued_count == base || $urandom_range(0, 9) < 7)
        write_reg(REG_TRIG_HIGH, ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 6));
      if (queued_count == base || $urandom_range(0, 9) < 7)
        write_reg(REG_RISE_TO, $urandom_range(0, 16));
      if (queued_count == base || $urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        write_reg(REG_WIDTH_TO, (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 40));
      end
      rise_cap = (rg_cfg.rise_timeout_us > 20) ? 21 : int'(rg_cfg.rise_timeout_us) + 1;
      echo_cap = (rg_cfg.width_timeout_us > 40) ? 42 : int'(rg_cfg.width_timeout_us) + 2;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 10))
            push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          queue_measurement($urandom_range(0, rise_cap), $urandom_range(0, echo_cap));
        end
      end
    end

    drain_ticks();
    repeat (5) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d report words never arrived", $time, pending_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
